>>> src/sdes_pkg.sv
// Shared types, permutation tables and S-box helpers for the S-DES cipher.
// Has no dependencies; every other file in this block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sdes_pkg;

   // Both round subkeys, as the key schedule delivers them.
   typedef struct packed {
      logic [7:0] k1;
      logic [7:0] k2;
   } subkey_pair_type;

   // Permutation tables. Entries are 1-based positions, position 1 is the MSB.
   localparam int P10_TAB   [10] = '{3, 5, 2, 7, 4, 10, 1, 9, 8, 6};
   localparam int P8_TAB    [8]  = '{6, 3, 7, 4, 8, 5, 10, 9};
   localparam int IP_TAB    [8]  = '{2, 6, 3, 1, 4, 8, 5, 7};
   localparam int IPINV_TAB [8]  = '{4, 1, 3, 5, 7, 2, 8, 6};
   localparam int EP_TAB    [8]  = '{4, 1, 2, 3, 2, 3, 4, 1};
   localparam int P4_TAB    [4]  = '{2, 4, 3, 1};

   // S-box contents, indexed [row][column].
   localparam logic [1:0] SBOX0_TAB [4][4] = '{
      '{2'd1, 2'd0, 2'd3, 2'd2},
      '{2'd3, 2'd2, 2'd1, 2'd0},
      '{2'd0, 2'd2, 2'd1, 2'd3},
      '{2'd3, 2'd1, 2'd0, 2'd2}
   };
   localparam logic [1:0] SBOX1_TAB [4][4] = '{
      '{2'd0, 2'd1, 2'd2, 2'd3},
      '{2'd2, 2'd3, 2'd1, 2'd0},
      '{2'd3, 2'd0, 2'd1, 2'd2},
      '{2'd2, 2'd1, 2'd0, 2'd3}
   };

   // P10 on the raw key.
   function automatic logic [9:0] perm_p10(input logic [9:0] v);
      logic [9:0] r;
      r = '0;
      for (int i = 0; i < 10; i++) begin
         r[9 - i] = v[10 - P10_TAB[i]];
      end
      return r;
   endfunction

   // P8 picks a subkey out of the 10-bit schedule word.
   function automatic logic [7:0] perm_p8(input logic [9:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[10 - P8_TAB[i]];
      end
      return r;
   endfunction

   // Rotate each 5-bit half left by one.
   function automatic logic [9:0] rot_halves(input logic [9:0] v);
      return {v[8:5], v[9], v[3:0], v[4]};
   endfunction

   // Initial permutation.
   function automatic logic [7:0] perm_ip(input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[8 - IP_TAB[i]];
      end
      return r;
   endfunction

   // Inverse of the initial permutation.
   function automatic logic [7:0] perm_ipinv(input logic [7:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[8 - IPINV_TAB[i]];
      end
      return r;
   endfunction

   // Expand the right nibble to eight bits.
   function automatic logic [7:0] perm_ep(input logic [3:0] v);
      logic [7:0] r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[4 - EP_TAB[i]];
      end
      return r;
   endfunction

   // P4 on the concatenated S-box outputs.
   function automatic logic [3:0] perm_p4(input logic [3:0] v);
      logic [3:0] r;
      r = '0;
      for (int i = 0; i < 4; i++) begin
         r[3 - i] = v[4 - P4_TAB[i]];
      end
      return r;
   endfunction

   // Row comes from the outer bits, column from the inner bits.
   function automatic logic [1:0] sbox0(input logic [3:0] nib);
      return SBOX0_TAB[{nib[3], nib[0]}][{nib[2], nib[1]}];
   endfunction

   function automatic logic [1:0] sbox1(input logic [3:0] nib);
      return SBOX1_TAB[{nib[3], nib[0]}][{nib[2], nib[1]}];
   endfunction

endpackage

`default_nettype wire

>>> src/sdes_block_cipher.sv
// S-DES block cipher: one 8-bit block encrypted or decrypted per cycle.
// Accepts a beat on every cycle that start is high (busy is always low). The
// result appears on rsp_block_out with rsp_valid high for exactly one cycle. It
// is carried from the input register to the result register, and the receiver
// cannot stall it. Throughput is one block per clock. The
// whole cipher (IP, both rounds and IP inverse) is one combinational pass between
// the input register and the result register. The subkeys are derived and
// registered when csr_write_en writes the key, so the key may only change while
// no beat is in flight. Reset clears the key to zero.
// Depends on sdes_pkg, sdes_keysched and sdes_round.
`timescale 1ns / 1ps
`default_nettype none

module sdes_block_cipher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_en,
   input  wire logic [9:0] csr_write_data,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_func,
   input  wire logic [7:0] req_block_in,
   output logic            rsp_valid,
   output logic      [7:0] rsp_block_out
);
   import sdes_pkg::*;

   subkey_pair_type subkeys_in, subkeys_ff;
   logic            req_valid_ff;
   logic            func_ff;
   logic [7:0]      block_ff;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_block_ff;
   logic [7:0]      rsp_block_in;
   logic [7:0]      first_key;
   logic [7:0]      second_key;
   logic [7:0]      ip_out;
   logic [7:0]      round1_out;
   logic [7:0]      round2_out;

   // The block never stalls its sender.
   assign busy = 1'b0;

   // Subkeys are computed from the key being written.
   sdes_keysched u_keysched (
      .key     (csr_write_data),
      .subkeys (subkeys_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         subkeys_ff <= '0;
      end else if (csr_write_en) begin
         subkeys_ff <= subkeys_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start & ~busy;
      end
      func_ff  <= req_func;
      block_ff <= req_block_in;
   end

   // Decryption runs the subkeys in reverse order.
   assign first_key  = func_ff ? subkeys_ff.k2 : subkeys_ff.k1;
   assign second_key = func_ff ? subkeys_ff.k1 : subkeys_ff.k2;

   assign ip_out = perm_ip(block_ff);

   sdes_round u_round1 (
      .data_in  (ip_out),
      .subkey   (first_key),
      .data_out (round1_out)
   );

   // Halves swap between the two rounds.
   sdes_round u_round2 (
      .data_in  ({round1_out[3:0], round1_out[7:4]}),
      .subkey   (second_key),
      .data_out (round2_out)
   );

   assign rsp_block_in = perm_ipinv(round2_out);

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

endmodule

`default_nettype wire

>>> src/sdes_keysched.sv
// Key schedule: derives both round subkeys from the 10-bit key.
// Depends on sdes_pkg for the permutation helpers and the subkey type.
`timescale 1ns / 1ps
`default_nettype none

module sdes_keysched (
   input  wire logic [9:0]               key,
   output sdes_pkg::subkey_pair_type     subkeys
);
   import sdes_pkg::*;

   logic [9:0] key_p10;
   logic [9:0] key_rot1;
   logic [9:0] key_rot2;

   // P10, then one rotate for K1 and a second rotate for K2.
   assign key_p10    = perm_p10(key);
   assign key_rot1   = rot_halves(key_p10);
   assign key_rot2   = rot_halves(key_rot1);
   assign subkeys.k1 = perm_p8(key_rot1);
   assign subkeys.k2 = perm_p8(key_rot2);

endmodule

`default_nettype wire

>>> src/sdes_round.sv
// One Feistel round: expansion, subkey mix, S-boxes and P4 folded into the left half.
// Depends on sdes_pkg for the expansion, S-box and P4 helpers.
`timescale 1ns / 1ps
`default_nettype none

module sdes_round (
   input  wire logic [7:0] data_in,
   input  wire logic [7:0] subkey,
   output logic      [7:0] data_out
);
   import sdes_pkg::*;

   logic [7:0] mixed;
   logic [3:0] sbox_out;

   // Expand the right half and mix in the subkey.
   assign mixed = perm_ep(data_in[3:0]) ^ subkey;

   // High nibble goes to the first S-box, low nibble to the second.
   assign sbox_out = {sbox0(mixed[7:4]), sbox1(mixed[3:0])};

   // The right half passes through; the left half takes the round output.
   assign data_out = {data_in[7:4] ^ perm_p4(sbox_out), data_in[3:0]};

endmodule

`default_nettype wire
